// ----- hw/rtl/adbe_pkg.sv -----
// Shared types and constants for the audio delta bit-pack encoder.
package adbe_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COUNT_W  = 4;
	localparam int WORD_W   = SAMPLE_W - 1 + COUNT_W + 1;  // count, sign, up to 15 payload bits
	localparam int PEND_W   = 7;
	localparam int PCNT_W   = 3;
	localparam int ACC_W    = WORD_W + PEND_W;              // 27 bits at most in flight
	localparam int TOTAL_W  = 5;
	localparam int JOB_W    = 32;                           // four bytes, zero padded
	localparam int NBYTES_W = 3;

	// Input transaction
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       final_sample;
	} sample_t;

	// Output transaction
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       stream_end;
	} byte_t;

	// Work handed from the front end to the byte emitter
	typedef struct packed {
		logic [JOB_W-1:0]    data;
		logic [NBYTES_W-1:0] nbytes;
		logic                fin;
	} job_t;

endpackage

// ----- hw/rtl/audio_delta_bitpack_encoder_top.sv -----
// Top level of the audio delta bit-pack encoder.
//
// Input channel (sample_valid, sample_stall, sample_data) takes one 16-bit
// sample per transaction; final_sample marks the end of a stream.
// Output channel (byte_valid, byte_stall, byte_data) delivers packed bytes,
// LSB-first, with run_last on the last byte caused by a sample and
// stream_end on the final byte of the stream.
// A sample's first byte passes the stage 1 register, a queue entry, the
// emitter's job register and the output register. A sample completes 0
// to 4 bytes, which the emitter sends one per cycle while byte_stall is
// low. Short code words run at one sample per cycle while the queue has
// room; a long code word completes up to 3 bytes, a final sample up to 4.
// A queue of QUEUE_DEPTH jobs decouples packing from byte output, so the
// input keeps accepting while the receiver stalls until the queue fills;
// then sample_stall rises. Stalled output bytes hold.
// Reset clears the predictor, the packer and the queue; the block is
// ready in the first cycle after reset.
module audio_delta_bitpack_encoder_top import adbe_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_stall,
	input  sample_t sample_data,
	output logic    byte_valid,
	input  logic    byte_stall,
	output byte_t   byte_data
);

	logic push, pop, q_full, q_empty;
	job_t wr_job, rd_job;

	adbe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_data  (sample_data),
		.q_full       (q_full),
		.push         (push),
		.job          (wr_job)
	);

	adbe_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	adbe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (rd_job),
		.q_empty    (q_empty),
		.pop        (pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data)
	);

endmodule

// ----- hw/rtl/adbe_front.sv -----
// Front end: prediction, code word build and bit packing into byte jobs.
module adbe_front import adbe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_stall,
	input  sample_t sample_data,
	input  logic    q_full,
	output logic    push,
	output job_t    job
);

	logic [SAMPLE_W-1:0] last_q, prev_q;
	logic [PEND_W-1:0]   pend_bits_q;
	logic [PCNT_W-1:0]   pend_cnt_q;
	logic [SAMPLE_W-1:0] err_s1;
	logic                fin_s1;
	logic                valid_s1;

	logic                in_fire;
	logic [SAMPLE_W-1:0] pred;
	logic                neg;
	logic [14:0]         mag;
	logic [COUNT_W-1:0]  n;
	logic [15:0]         mask;
	logic [WORD_W-1:0]   word;
	logic [ACC_W-1:0]    acc;
	logic [TOTAL_W-1:0]  total;
	logic [1:0]          full_bytes;
	logic [NBYTES_W-1:0] nbytes;
	logic [ACC_W-1:0]    acc_rest;

	// Stage 1 holds while the queue is full
	assign sample_stall = valid_s1 && q_full;
	assign in_fire      = sample_valid && !sample_stall;

	// Second order predictor, wraps at 16 bits
	assign pred = {last_q[14:0], 1'b0} - prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_q   <= '0;
			prev_q   <= '0;
		end else begin
			if (!sample_stall) begin
				valid_s1 <= sample_valid;
			end
			if (in_fire) begin
				if (sample_data.final_sample) begin
					last_q <= '0;
					prev_q <= '0;
				end else begin
					last_q <= $unsigned(sample_data.sample);
					prev_q <= last_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			err_s1 <= $unsigned(sample_data.sample) - pred;
			fin_s1 <= sample_data.final_sample;
		end
	end

	// Stage 2: bit length of the magnitude, code word and packing
	assign neg = err_s1[15];
	assign mag = neg ? ~err_s1[14:0] : err_s1[14:0];

	always_comb begin
		n = '0;
		for (int i = 0; i < 15; i++) begin
			if (mag[i]) begin
				n = COUNT_W'(i + 1);
			end
		end
	end

	assign mask       = 16'((17'd1 << n) - 17'd1);
	assign word       = {err_s1[14:0] & mask[14:0], neg, n};
	assign acc        = ACC_W'(pend_bits_q) | (ACC_W'(word) << pend_cnt_q);
	assign total      = TOTAL_W'(pend_cnt_q) + TOTAL_W'(n) + TOTAL_W'(5);
	assign full_bytes = total[4:3];
	assign nbytes     = fin_s1 ? NBYTES_W'(full_bytes) + NBYTES_W'(|total[2:0])
	                           : NBYTES_W'(full_bytes);
	assign acc_rest   = acc >> {full_bytes, 3'b000};

	assign push       = valid_s1 && !q_full && (nbytes != '0);
	assign job.data   = JOB_W'(acc);
	assign job.nbytes = nbytes;
	assign job.fin    = fin_s1;

	// Leftover bits; a final sample clears the packer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else if (valid_s1 && !q_full) begin
			if (fin_s1) begin
				pend_bits_q <= '0;
				pend_cnt_q  <= '0;
			end else begin
				pend_bits_q <= acc_rest[PEND_W-1:0];
				pend_cnt_q  <= total[2:0];
			end
		end
	end

	// A final sample returns the predictor to reset
	a_pred_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && sample_data.final_sample |=> last_q == '0 && prev_q == '0)
		else $error("predictor not cleared after final sample");

	// A final sample always produces at least one byte
	a_fin_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !q_full && fin_s1 |-> push)
		else $error("final sample produced no byte");

endmodule

// ----- hw/rtl/adbe_fifo.sv -----
// Small register queue of byte jobs between front end and emitter.
module adbe_fifo import adbe_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	input  logic pop,
	output job_t rd_job,
	output logic full,
	output logic empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full   = count_q == CNT_W'(DEPTH);
	assign empty  = count_q == '0;
	assign rd_job = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

	// Pointers wrap explicitly so any depth of two or more works
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty))
		else $error("queue overflow or underflow");

endmodule

// ----- hw/rtl/adbe_back.sv -----
// Back end: splits a job into bytes and drives the output register.
module adbe_back import adbe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  job_t  job,
	input  logic  q_empty,
	output logic  pop,
	output logic  byte_valid,
	input  logic  byte_stall,
	output byte_t byte_data
);

	logic [JOB_W-1:0]    data_q;
	logic [NBYTES_W-1:0] rem_q;
	logic                fin_q;
	logic                busy_q;
	logic                out_valid_q;
	byte_t               out_q;

	logic out_free, emit, last_of_job;

	assign out_free    = !out_valid_q || !byte_stall;
	assign emit        = busy_q && out_free;
	assign last_of_job = rem_q == NBYTES_W'(1);
	assign pop         = !q_empty && (!busy_q || (emit && last_of_job));

	// Current job, one byte per cycle while the output is not stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rem_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			rem_q  <= job.nbytes;
		end else if (emit) begin
			rem_q <= rem_q - 1'b1;
			if (last_of_job) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= job.data;
			fin_q  <= job.fin;
		end else if (emit) begin
			data_q <= data_q >> 8;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!byte_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_byte   <= data_q[7:0];
			out_q.run_last   <= last_of_job;
			out_q.stream_end <= last_of_job && fin_q;
		end
	end

	assign byte_valid = out_valid_q;
	assign byte_data  = out_q;

	a_busy_rem: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q != '0)
		else $error("emitter busy with no bytes left");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.stream_end |-> out_q.run_last)
		else $error("stream end without run last");

endmodule
